/* design/iee_pkg.sv */
// Package for the infix expression evaluator: codes, state types,
// ASCII constants and the shared fixed-point helper functions.
// No dependencies.
`default_nettype none
package iee_pkg;

    localparam int STACK_DEPTH_DEF     = 16;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 9;

    localparam logic [2:0] OPC_LPAR  = 3'd0;
    localparam logic [2:0] OPC_ADD   = 3'd1;
    localparam logic [2:0] OPC_SUB   = 3'd2;
    localparam logic [2:0] OPC_MUL   = 3'd3;
    localparam logic [2:0] OPC_DIV   = 3'd4;
    localparam logic [2:0] OPC_OTHER = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIVZERO   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAG   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955160;

    localparam logic [2:0] NF_ACTIVE = 3'd1;
    localparam logic [2:0] NF_POINT  = 3'd2;
    localparam logic [2:0] NF_CLOSED = 3'd4;

    typedef enum logic [1:0] {AK_MUL, AK_DIV, AK_CONV} alu_kind_t;

    typedef struct packed {
        logic      start;
        alu_kind_t kind;
    } alu_req_t;

    typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_MRND, A_DRND} alu_state_t;

    typedef enum logic [1:0] {LM_RPAR, LM_OP, LM_FINAL} loop_mode_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHAR, S_CWAIT, S_DISP, S_POST, S_LOOP, S_LTOP,
        S_RED1, S_RED2, S_RWAIT, S_FINISH, S_FRD, S_EMIT
    } ctl_state_t;

    function automatic logic [63:0] sat_from_mag(input logic neg, input logic [63:0] mag,
                                                 input logic over);
        logic [63:0] r;
        if (neg) begin
            r = (over || mag >= NEG_MAG) ? NEG_MAG : (~mag) + 64'd1;
        end else begin
            r = (over || mag > POS_MAX) ? POS_MAX : mag;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag_of(input logic [63:0] v);
        return v[63] ? (~v) + 64'd1 : v;
    endfunction

    function automatic logic [1:0] prec(input logic [2:0] op);
        logic [1:0] p;
        case (op)
            OPC_ADD, OPC_SUB: p = 2'd1;
            OPC_MUL, OPC_DIV: p = 2'd2;
            default:          p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [63:0] pow10(input logic [3:0] k);
        logic [63:0] p;
        case (k)
            4'd0:    p = 64'd1;
            4'd1:    p = 64'd10;
            4'd2:    p = 64'd100;
            4'd3:    p = 64'd1000;
            4'd4:    p = 64'd10000;
            4'd5:    p = 64'd100000;
            4'd6:    p = 64'd1000000;
            4'd7:    p = 64'd10000000;
            4'd8:    p = 64'd100000000;
            4'd9:    p = 64'd1000000000;
            4'd10:   p = 64'd10000000000;
            4'd11:   p = 64'd100000000000;
            4'd12:   p = 64'd1000000000000;
            4'd13:   p = 64'd10000000000000;
            4'd14:   p = 64'd100000000000000;
            default: p = 64'd1000000000000000;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

/* design/iee_stack_mem.sv */
// Stack storage: one write port, one read port, registered read data.
// Uses no package items.
`default_nettype none
module iee_stack_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* design/iee_alu.sv */
// Iterative arithmetic unit: shift-add multiply (64 steps), restoring divide
// (128 steps) and decimal-to-fixed conversion, each with rounding and saturation.
// Depends on iee_pkg.
`default_nettype none
module iee_alu import iee_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire alu_req_t    req,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      result
);
    localparam logic [127:0] HALF = (FRAC_BITS > 0) ? (128'd1 << (FRAC_BITS - 1)) : 128'd0;

    alu_state_t   state_reg, state_next;
    logic [6:0]   cnt_reg;
    logic         neg_reg, over_reg, done_reg;
    logic [63:0]  x_reg, d_reg, r_reg, q_reg, hi_reg, lo_reg, res_reg;
    logic [127:0] dvd_reg;
    logic [64:0]  msum;
    logic [63:0]  rs, rsub, qinc;
    logic         ge;
    logic [127:0] prnd, psh;

    always_comb begin
        msum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, x_reg} : 65'd0);
        rs   = {r_reg[62:0], dvd_reg[127]};
        ge   = rs >= d_reg;
        rsub = rs - d_reg;
        qinc = q_reg + 64'd1;
        prnd = {hi_reg, lo_reg} + HALF;
        psh  = prnd >> FRAC_BITS;
        state_next = state_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    state_next = (req.kind == AK_MUL) ? A_MUL : A_DIV;
                end
            end
            A_MUL:   if (cnt_reg == 7'd63) state_next = A_MRND;
            A_DIV:   if (cnt_reg == 7'd127) state_next = A_DRND;
            A_MRND:  state_next = A_IDLE;
            A_DRND:  state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == A_MRND) || (state_reg == A_DRND);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            A_IDLE: begin
                cnt_reg  <= 7'd0;
                over_reg <= 1'b0;
                r_reg    <= 64'd0;
                q_reg    <= 64'd0;
                hi_reg   <= 64'd0;
                if (req.kind == AK_CONV) begin
                    neg_reg <= 1'b0;
                    x_reg   <= a;
                    d_reg   <= b;
                    lo_reg  <= b;
                    dvd_reg <= {64'd0, a} << FRAC_BITS;
                end else begin
                    neg_reg <= a[63] ^ b[63];
                    x_reg   <= mag_of(a);
                    d_reg   <= mag_of(b);
                    lo_reg  <= mag_of(b);
                    dvd_reg <= {64'd0, mag_of(a)} << FRAC_BITS;
                end
            end
            A_MUL: begin
                hi_reg  <= msum[64:1];
                lo_reg  <= {msum[0], lo_reg[63:1]};
                cnt_reg <= cnt_reg + 7'd1;
            end
            A_DIV: begin
                r_reg   <= ge ? rsub : rs;
                dvd_reg <= {dvd_reg[126:0], 1'b0};
                q_reg   <= {q_reg[62:0], ge};
                if (!cnt_reg[6] && ge) begin
                    over_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 7'd1;
            end
            A_MRND: res_reg <= sat_from_mag(neg_reg, psh[63:0], |psh[127:64]);
            A_DRND: begin
                if (r_reg >= d_reg - r_reg) begin
                    res_reg <= sat_from_mag(neg_reg, qinc, over_reg || (q_reg == '1));
                end else begin
                    res_reg <= sat_from_mag(neg_reg, q_reg, over_reg);
                end
            end
            default: res_reg <= res_reg;
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

/* design/infix_expression_evaluator.sv */
// Infix expression evaluator, one ASCII character per item, shunting-yard order.
// Digits pass through S_CHAR and S_POST, spaces also through S_DISP; each number end waits on
// the divider, each reduction is done in place for + and -, through the iterative ALU for * and /.
// Throughput is bounded by the shared iterative divider and multiplier.
// Reset (aresetn, synchronous, active low) clears counts, number state and error.
`default_nettype none
module infix_expression_evaluator import iee_pkg::*; #(
    parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [63:0] result_value, [66:64] status
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    ctl_state_t  state_reg, state_next;
    loop_mode_t  mode_reg, mode_next;
    logic [CW-1:0] vcnt_reg, vcnt_next, ocnt_reg, ocnt_next, vm1, vm2, om1;
    logic [63:0] acc_reg, acc_next, acc10;
    logic [3:0]  fdc_reg, fdc_next;
    logic [2:0]  nflg_reg, nflg_next, err_reg, err_next;
    logic [7:0]  chr_reg;
    logic        last_reg;
    logic [2:0]  opc_reg, opc_next, rop_reg, rop_next;
    logic [63:0] b_reg, b_next, res_reg, res_next;
    logic        mval_reg;
    logic [66:0] mdat_reg;

    logic          v_we, o_we;
    logic [AW-1:0] v_waddr, v_raddr, o_waddr, o_raddr;
    logic [63:0]   v_wdata, v_rdata;
    logic [2:0]    o_wdata, o_rdata;
    alu_req_t      areq;
    logic [63:0]   alu_a, alu_b, alu_res;
    logic          alu_done;
    logic          is_digit, is_ws, load_out;
    logic [2:0]    chr_op;

    iee_stack_mem #(.DEPTH(STACK_DEPTH), .WIDTH(64)) u_vstk (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    iee_stack_mem #(.DEPTH(STACK_DEPTH), .WIDTH(3)) u_ostk (
        .aclk(aclk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    iee_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .aclk(aclk), .aresetn(aresetn), .req(areq), .a(alu_a), .b(alu_b),
        .done(alu_done), .result(alu_res)
    );

    assign vm1   = vcnt_reg - CW'(1);
    assign vm2   = vcnt_reg - CW'(2);
    assign om1   = ocnt_reg - CW'(1);
    assign acc10 = (acc_reg << 3) + (acc_reg << 1) + {60'd0, chr_reg[3:0]};
    assign is_digit = (chr_reg >= CH_0) && (chr_reg <= CH_9);
    assign is_ws    = (chr_reg == CH_SPACE) || ((chr_reg >= CH_TAB) && (chr_reg <= CH_CR));

    always_comb begin
        case (chr_reg)
            CH_PLUS:  chr_op = OPC_ADD;
            CH_MINUS: chr_op = OPC_SUB;
            CH_STAR:  chr_op = OPC_MUL;
            CH_SLASH: chr_op = OPC_DIV;
            default:  chr_op = OPC_OTHER;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        vcnt_next  = vcnt_reg;
        ocnt_next  = ocnt_reg;
        acc_next   = acc_reg;
        fdc_next   = fdc_reg;
        nflg_next  = nflg_reg;
        err_next   = err_reg;
        opc_next   = opc_reg;
        rop_next   = rop_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        v_we = 1'b0;  v_waddr = vcnt_reg[AW-1:0];  v_wdata = alu_res;
        v_raddr = vm1[AW-1:0];
        o_we = 1'b0;  o_waddr = ocnt_reg[AW-1:0];  o_wdata = opc_reg;
        o_raddr = om1[AW-1:0];
        areq.start = 1'b0;  areq.kind = AK_CONV;
        alu_a = acc_reg;    alu_b = pow10(fdc_reg);
        load_out = 1'b0;
        s_tready = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_CHAR;
            S_CHAR: begin
                if (err_reg != ST_OK) begin
                    state_next = S_POST;
                end else if (is_digit || chr_reg == CH_POINT) begin
                    nflg_next  = nflg_reg | NF_ACTIVE;
                    state_next = S_POST;
                    if (chr_reg == CH_POINT) begin
                        nflg_next = nflg_reg | NF_ACTIVE
                                  | ((nflg_reg & NF_POINT) != 3'd0 ? NF_CLOSED : NF_POINT);
                    end else if ((nflg_reg & NF_POINT) == 3'd0) begin
                        acc_next = (acc_reg > ACC_LIMIT) ? '1 : acc10;
                    end else if ((nflg_reg & NF_CLOSED) == 3'd0
                                 && fdc_reg < 4'(MAX_FRAC_DIGITS) && acc_reg <= ACC_LIMIT) begin
                        acc_next = acc10;
                        fdc_next = fdc_reg + 4'd1;
                    end
                end else if ((nflg_reg & NF_ACTIVE) != 3'd0) begin
                    areq.start = 1'b1;
                    mode_next  = LM_OP;
                    state_next = S_CWAIT;
                end else begin
                    state_next = S_DISP;
                end
            end
            S_CWAIT: begin
                if (alu_done) begin
                    if (vcnt_reg >= DEPTH_C) begin
                        if (err_reg == ST_OK) err_next = ST_OVERFLOW;
                    end else begin
                        v_we      = 1'b1;
                        vcnt_next = vcnt_reg + CW'(1);
                    end
                    acc_next   = 64'd0;
                    fdc_next   = 4'd0;
                    nflg_next  = 3'd0;
                    state_next = (mode_reg == LM_FINAL) ? S_LOOP : S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_POST;
                if (err_reg == ST_OK && !is_ws) begin
                    if (chr_reg == CH_LPAR) begin
                        if (ocnt_reg >= DEPTH_C) begin
                            err_next = ST_OVERFLOW;
                        end else begin
                            o_we      = 1'b1;
                            o_wdata   = OPC_LPAR;
                            ocnt_next = ocnt_reg + CW'(1);
                        end
                    end else if (chr_reg == CH_RPAR) begin
                        mode_next  = LM_RPAR;
                        state_next = S_LOOP;
                    end else begin
                        opc_next   = chr_op;
                        mode_next  = LM_OP;
                        state_next = S_LOOP;
                    end
                end
            end
            S_POST: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else begin
                    mode_next = LM_FINAL;
                    if (err_reg == ST_OK && (nflg_reg & NF_ACTIVE) != 3'd0) begin
                        areq.start = 1'b1;
                        state_next = S_CWAIT;
                    end else begin
                        acc_next   = 64'd0;
                        fdc_next   = 4'd0;
                        nflg_next  = 3'd0;
                        state_next = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                if (err_reg != ST_OK) begin
                    state_next = (mode_reg == LM_FINAL) ? S_FINISH : S_POST;
                end else if (ocnt_reg == '0) begin
                    case (mode_reg)
                        LM_RPAR: begin
                            err_next   = ST_MALFORMED;
                            state_next = S_POST;
                        end
                        LM_OP: begin
                            o_we       = 1'b1;
                            ocnt_next  = ocnt_reg + CW'(1);
                            state_next = S_POST;
                        end
                        default: state_next = S_FINISH;
                    endcase
                end else begin
                    state_next = S_LTOP;
                end
            end
            S_LTOP: begin
                state_next = S_LOOP;
                rop_next   = o_rdata;
                if (mode_reg == LM_RPAR && o_rdata == OPC_LPAR) begin
                    ocnt_next  = om1;
                    state_next = S_POST;
                end else if (mode_reg == LM_OP
                             && (o_rdata == OPC_LPAR || prec(o_rdata) < prec(opc_reg))) begin
                    if (ocnt_reg >= DEPTH_C) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        o_we      = 1'b1;
                        ocnt_next = ocnt_reg + CW'(1);
                    end
                    state_next = S_POST;
                end else if (mode_reg == LM_FINAL && o_rdata == OPC_LPAR) begin
                    err_next = ST_MALFORMED;
                end else begin
                    ocnt_next = om1;
                    if (vcnt_reg < CW'(2)) begin
                        err_next = ST_MALFORMED;
                    end else begin
                        state_next = S_RED1;
                    end
                end
            end
            S_RED1: begin
                b_next     = v_rdata;
                v_raddr    = vm2[AW-1:0];
                state_next = S_RED2;
            end
            S_RED2: begin
                alu_a     = v_rdata;
                alu_b     = b_reg;
                v_waddr   = vm2[AW-1:0];
                state_next = S_LOOP;
                case (rop_reg)
                    OPC_ADD, OPC_SUB: begin
                        v_we      = 1'b1;
                        v_wdata   = (rop_reg == OPC_SUB) ? v_rdata - b_reg : v_rdata + b_reg;
                        if (v_rdata[63] == (b_reg[63] ^ (rop_reg == OPC_SUB))
                            && v_wdata[63] != v_rdata[63]) begin
                            v_wdata = v_rdata[63] ? NEG_MAG : POS_MAX;
                        end
                        vcnt_next = vm1;
                    end
                    OPC_MUL: begin
                        areq.start = 1'b1;
                        areq.kind  = AK_MUL;
                        state_next = S_RWAIT;
                    end
                    OPC_DIV: begin
                        if (b_reg == 64'd0) begin
                            err_next = ST_DIVZERO;
                        end else begin
                            areq.start = 1'b1;
                            areq.kind  = AK_DIV;
                            state_next = S_RWAIT;
                        end
                    end
                    default: begin
                        v_we      = 1'b1;
                        v_wdata   = 64'd0;
                        vcnt_next = vm1;
                    end
                endcase
            end
            S_RWAIT: begin
                v_waddr = vm2[AW-1:0];
                if (alu_done) begin
                    v_we       = 1'b1;
                    vcnt_next  = vm1;
                    state_next = S_LOOP;
                end
            end
            S_FINISH: begin
                res_next   = 64'd0;
                state_next = S_EMIT;
                v_raddr    = '0;
                if (err_reg == ST_OK) begin
                    if (vcnt_reg == '0) begin
                        err_next = ST_EMPTY;
                    end else if (vcnt_reg != CW'(1)) begin
                        err_next = ST_MALFORMED;
                    end else begin
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD: begin
                res_next   = v_rdata;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!mval_reg || m_tready) begin
                    load_out   = 1'b1;
                    vcnt_next  = '0;
                    ocnt_next  = '0;
                    acc_next   = 64'd0;
                    fdc_next   = 4'd0;
                    nflg_next  = 3'd0;
                    err_next   = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= LM_OP;
            vcnt_reg  <= '0;
            ocnt_reg  <= '0;
            acc_reg   <= 64'd0;
            fdc_reg   <= 4'd0;
            nflg_reg  <= 3'd0;
            err_reg   <= ST_OK;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            vcnt_reg  <= vcnt_next;
            ocnt_reg  <= ocnt_next;
            acc_reg   <= acc_next;
            fdc_reg   <= fdc_next;
            nflg_reg  <= nflg_next;
            err_reg   <= err_next;
            if (load_out) begin
                mval_reg <= 1'b1;
            end else if (m_tready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        opc_reg <= opc_next;
        rop_reg <= rop_next;
        b_reg   <= b_next;
        res_reg <= res_next;
        if (s_tvalid && s_tready) begin
            chr_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
        if (load_out) begin
            mdat_reg <= {err_reg, (err_reg == ST_OK) ? res_reg : 64'd0};
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {5'd0, mdat_reg};

    a_vcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg <= DEPTH_C) else $error("value count beyond depth");
    a_ocnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg <= DEPTH_C) else $error("operator count beyond depth");
    a_accept_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == S_CHAR) else $error("item not taken up");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[66:64] != ST_OK) |-> m_tdata[63:0] == 64'd0)
        else $error("error result carries a value");
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && load_out) |=> (vcnt_reg == '0 && err_reg == ST_OK))
        else $error("state not cleared after result");
endmodule
`default_nettype wire

/* sim/tb_infix_expression_evaluator.sv */
// Testbench for the infix expression evaluator: drives ASCII expressions as items,
// predicts value and status with its own shunting-yard model and checks each result.
// Depends on iee_pkg and infix_expression_evaluator.
`timescale 1ns / 100ps

class expr_scoreboard;
    logic [63:0] vals[16];
    int          nval;
    logic [2:0]  ops[16];
    int          nop;
    logic [63:0] acc;
    int          fdig;
    logic [2:0]  nflags;
    logic [2:0]  err;
    logic [66:0] pending[$];
    int          fails;

    function new();
        fails = 0;
        clear();
    endfunction

    function void clear();
        nval = 0; nop = 0; acc = 0; fdig = 0; nflags = 0; err = iee_pkg::ST_OK;
    endfunction

    function void set_err(logic [2:0] e);
        if (err == iee_pkg::ST_OK) err = e;
    endfunction

    function logic [63:0] sat(bit neg, logic [63:0] mag, bit over);
        if (neg) return (over || mag >= iee_pkg::NEG_MAG) ? iee_pkg::NEG_MAG : -mag;
        return (over || mag > iee_pkg::POS_MAX) ? iee_pkg::POS_MAX : mag;
    endfunction

    function logic [63:0] absval(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function logic [63:0] to_fixed();
        logic [63:0] p, ip, rem;
        logic [64:0] r2;
        logic [63:0] fr;
        p = 1;
        for (int k = 0; k < fdig && k < 15; k++) p = p * 10;
        ip = acc / p;
        rem = acc % p;
        if (ip > (iee_pkg::POS_MAX >> 16)) return iee_pkg::POS_MAX;
        fr = 0;
        for (int k = 0; k < 16; k++) begin
            r2 = {rem, 1'b0};
            fr = fr << 1;
            if (r2 >= p) begin
                r2 = r2 - p;
                fr[0] = 1'b1;
            end
            rem = r2[63:0];
        end
        if (rem >= p - rem) fr++;
        ip = (ip << 16) + fr;
        return ip > iee_pkg::POS_MAX ? iee_pkg::POS_MAX : ip;
    endfunction

    function void push_val(logic [63:0] v);
        if (nval >= 16) set_err(iee_pkg::ST_OVERFLOW);
        else vals[nval++] = v;
    endfunction

    function void close_number();
        if (nflags & iee_pkg::NF_ACTIVE) push_val(to_fixed());
        acc = 0; fdig = 0; nflags = 0;
    endfunction

    function int rank(logic [2:0] op);
        if (op == iee_pkg::OPC_ADD || op == iee_pkg::OPC_SUB) return 1;
        if (op == iee_pkg::OPC_MUL || op == iee_pkg::OPC_DIV) return 2;
        return 0;
    endfunction

    function void apply_top();
        logic [63:0] a, b, r, x, y;
        logic [127:0] prod, num, q;
        bit neg;
        logic [2:0] op;
        if (nop == 0) return;
        op = ops[--nop];
        if (nval < 2) begin
            set_err(iee_pkg::ST_MALFORMED);
            return;
        end
        b = vals[--nval];
        a = vals[--nval];
        neg = a[63] ^ b[63];
        x = absval(a);
        y = absval(b);
        r = 0;
        case (op)
            iee_pkg::OPC_ADD, iee_pkg::OPC_SUB: begin
                logic [63:0] bb;
                bb = (op == iee_pkg::OPC_SUB) ? ~b : b;
                r = (op == iee_pkg::OPC_SUB) ? a - b : a + b;
                if (a[63] == bb[63] && r[63] != a[63])
                    r = a[63] ? iee_pkg::NEG_MAG : iee_pkg::POS_MAX;
            end
            iee_pkg::OPC_MUL: begin
                prod = x * y;
                prod = (prod + 128'h8000) >> 16;
                r = sat(neg, prod[63:0], prod[127:64] != 0);
            end
            iee_pkg::OPC_DIV: begin
                if (b == 0) begin
                    set_err(iee_pkg::ST_DIVZERO);
                    return;
                end
                num = {64'd0, x} << 16;
                q = num / y;
                num = num % y;
                if (num[63:0] >= y - num[63:0]) q++;
                r = sat(neg, q[63:0], q[127:64] != 0);
            end
            default: r = 0;
        endcase
        vals[nval++] = r;
    endfunction

    function void take_char(logic [7:0] c);
        logic [2:0] op;
        if ((c >= iee_pkg::CH_0 && c <= iee_pkg::CH_9) || c == iee_pkg::CH_POINT) begin
            nflags |= iee_pkg::NF_ACTIVE;
            if (c == iee_pkg::CH_POINT) begin
                if (nflags & iee_pkg::NF_POINT) nflags |= iee_pkg::NF_CLOSED;
                else nflags |= iee_pkg::NF_POINT;
            end else if (!(nflags & iee_pkg::NF_POINT)) begin
                if (acc > iee_pkg::ACC_LIMIT) acc = '1;
                else acc = acc * 10 + (c - iee_pkg::CH_0);
            end else if (!(nflags & iee_pkg::NF_CLOSED) && fdig < 9
                         && acc <= iee_pkg::ACC_LIMIT) begin
                acc = acc * 10 + (c - iee_pkg::CH_0);
                fdig++;
            end
            return;
        end
        close_number();
        if (err != iee_pkg::ST_OK || c == iee_pkg::CH_SPACE
            || (c >= iee_pkg::CH_TAB && c <= iee_pkg::CH_CR)) return;
        if (c == iee_pkg::CH_LPAR) begin
            if (nop >= 16) set_err(iee_pkg::ST_OVERFLOW);
            else ops[nop++] = iee_pkg::OPC_LPAR;
            return;
        end
        if (c == iee_pkg::CH_RPAR) begin
            while (err == iee_pkg::ST_OK && nop > 0 && ops[nop-1] != iee_pkg::OPC_LPAR)
                apply_top();
            if (err != iee_pkg::ST_OK) return;
            if (nop > 0) nop--;
            else set_err(iee_pkg::ST_MALFORMED);
            return;
        end
        case (c)
            iee_pkg::CH_PLUS:  op = iee_pkg::OPC_ADD;
            iee_pkg::CH_MINUS: op = iee_pkg::OPC_SUB;
            iee_pkg::CH_STAR:  op = iee_pkg::OPC_MUL;
            iee_pkg::CH_SLASH: op = iee_pkg::OPC_DIV;
            default:           op = iee_pkg::OPC_OTHER;
        endcase
        while (err == iee_pkg::ST_OK && nop > 0 && ops[nop-1] != iee_pkg::OPC_LPAR
               && rank(ops[nop-1]) >= rank(op))
            apply_top();
        if (err != iee_pkg::ST_OK) return;
        if (nop >= 16) set_err(iee_pkg::ST_OVERFLOW);
        else ops[nop++] = op;
    endfunction

    function void note_input(logic [7:0] c, logic lst);
        logic [63:0] v;
        v = 0;
        if (err == iee_pkg::ST_OK) take_char(c);
        if (!lst) return;
        if (err == iee_pkg::ST_OK) close_number();
        while (err == iee_pkg::ST_OK && nop > 0) begin
            if (ops[nop-1] == iee_pkg::OPC_LPAR) set_err(iee_pkg::ST_MALFORMED);
            else apply_top();
        end
        if (err == iee_pkg::ST_OK) begin
            if (nval == 0) set_err(iee_pkg::ST_EMPTY);
            else if (nval != 1) set_err(iee_pkg::ST_MALFORMED);
            else v = vals[0];
        end
        pending.push_back({err, (err == iee_pkg::ST_OK) ? v : 64'd0});
        clear();
    endfunction

    function void check_result(logic [71:0] d);
        logic [66:0] e;
        if (pending.size() == 0) begin
            $error("result with none expected: %h", d);
            fails++;
            return;
        end
        e = pending.pop_front();
        if (d[63:0] !== e[63:0]) begin
            $error("result_value expected %h actual %h", e[63:0], d[63:0]);
            fails++;
        end
        if (d[66:64] !== e[66:64]) begin
            $error("status expected %0d actual %0d", e[66:64], d[66:64]);
            fails++;
        end
    endfunction
endclass

module tb_infix_expression_evaluator;
    import iee_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;

    int          send_idle = 0;
    int          recv_idle = 0;
    bit          done = 0;
    expr_scoreboard sb = new();

    infix_expression_evaluator dut (.*);

    initial forever #4 aclk = ~aclk;

    initial begin
        #400ms;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic lst);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= c;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(c, lst);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic string rand_number();
        string s;
        int n;
        s = "";
        n = $urandom_range(4, 1);
        if ($urandom_range(30) == 0) n = $urandom_range(22, 12);
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
        if ($urandom_range(2) == 0) begin
            s = {s, "."};
            n = $urandom_range(4);
            if ($urandom_range(15) == 0) n = $urandom_range(14, 9);
            for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
            if ($urandom_range(20) == 0) s = {s, ".7"};
        end
        return s;
    endfunction

    function automatic string rand_expr(input int depth);
        string s, opch;
        int n;
        n = $urandom_range(3, 1);
        s = "";
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                case ($urandom_range(3))
                    0: opch = "+";
                    1: opch = "-";
                    2: opch = "*";
                    default: opch = "/";
                endcase
                if ($urandom_range(3) == 0) s = {s, " "};
                s = {s, opch};
            end
            if (depth < 3 && $urandom_range(3) == 0) s = {s, "(", rand_expr(depth + 1), ")"};
            else s = {s, rand_number()};
        end
        return s;
    endfunction

    task automatic random_phase(input int items);
        int sent;
        string s;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) < 8) begin
                s = rand_expr(0);
                if ($urandom_range(15) == 0) s = {s, "/0"};
                if ($urandom_range(15) == 0) s = {"(((", s};
                if ($urandom_range(15) == 0) s = {s, "))"};
                send_text(s);
                sent += s.len();
            end else begin
                int n;
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++) send_char(8'($urandom_range(255)), i == n - 1);
                sent += n;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_text("1+2*3");
        send_text("(1+2)*3-4/8");
        send_text(".");
        send_text("1.5.25");
        send_text("0.1234567891234");
        send_text("99999999999999999999999");
        send_text("5/0");
        send_text("((((((((((((((((1");
        send_text("1 2");
        send_text("1+a");
        send_text("1)");
        send_text(" ");
        send_text("140737488355327*2");
        send_text("0-140737488355327-9");
        send_text("7/3");
        send_char(8'hFF, 1);
        send_text("1\t+\r2");
        drain();
        send_idle = 32; recv_idle = 70;
        random_phase(280);
        drain();
        send_idle = 70; recv_idle = 32;
        random_phase(270);
        send_idle = 0; recv_idle = 0;
        random_phase(270);
        drain();
        repeat (500) @(posedge aclk);
        if (sb.fails == 0 && sb.pending.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
